/* rtl/core/sdt_pkg.sv */
`timescale 1ns / 1ps

package sdt_pkg;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int THR_W      = 12;
  localparam int SHIFT_W    = 4;
  localparam int WFIRST_W   = 5;
  localparam int WLAST_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // crossing positions covered by the evaluation: the lowest window start minus
  // one up to the highest window end plus two, as signed positions
  localparam int POS_MIN   = -(2 ** (WFIRST_W - 1)) - 1;
  localparam int POS_MAX   = (2 ** WLAST_W) + 1;
  localparam int POS_CNT   = POS_MAX - POS_MIN + 1;
  localparam int SHIFT_MAX = (2 ** SHIFT_W) - 1;
  localparam int WIN_W     = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_PAIR_SHIFT   = 3'd1,
    REG_WINDOW_FIRST = 3'd2,
    REG_WINDOW_LAST  = 3'd3,
    REG_DOUBLE_MODE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]           threshold;
    logic [SHIFT_W-1:0]         pair_shift;
    logic signed [WFIRST_W-1:0] window_first;
    logic [WLAST_W-1:0]         window_last;
    logic                       double_mode;
  } cfg_t;

  typedef struct packed {
    logic triggered;
    logic settings_error;
  } verdict_t;

endpackage

/* rtl/core/sdt_cfg_regs.sv */
`timescale 1ns / 1ps

module sdt_cfg_regs
  import sdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_THRESHOLD:    cfg_nxt.threshold    = wr_data[THR_W-1:0];
        REG_PAIR_SHIFT:   cfg_nxt.pair_shift   = wr_data[SHIFT_W-1:0];
        REG_WINDOW_FIRST: cfg_nxt.window_first = $signed(wr_data[WFIRST_W-1:0]);
        REG_WINDOW_LAST:  cfg_nxt.window_last  = wr_data[WLAST_W-1:0];
        REG_DOUBLE_MODE:  cfg_nxt.double_mode  = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= '0;
      cfg_r.pair_shift   <= SHIFT_W'(1);
      cfg_r.window_first <= '0;
      cfg_r.window_last  <= '0;
      cfg_r.double_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/sdt_history.sv */
`timescale 1ns / 1ps

module sdt_history
  import sdt_pkg::*;
#(
  parameter int DEPTH = 24
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  sample_t sample,
  input  logic    bc_end,
  input  logic    taken,
  output sample_t hist [DEPTH],
  output logic    pend
);

  sample_t hist_r [DEPTH];
  logic    pend_r;
  logic    pend_nxt;

  // sample shift line, newest sample at the front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (accept) begin
      hist_r[0] <= sample;
      for (int i = 1; i < DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // a crossing end waits here until the result register takes its verdict
  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = bc_end;
    end else if (taken) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  assign hist = hist_r;
  assign pend = pend_r;

endmodule

/* rtl/core/sdt_eval.sv */
`timescale 1ns / 1ps

module sdt_eval
  import sdt_pkg::*;
#(
  parameter int SPC   = 12,
  parameter int DEPTH = 24
) (
  input  sample_t  hist [DEPTH],
  input  cfg_t     cfg,
  output verdict_t verdict
);

  localparam int EXT_CNT   = POS_CNT + SHIFT_MAX;
  localparam int EXT_IDX_W = $clog2(EXT_CNT);
  localparam int RUN_CNT   = POS_CNT - 2;

  sample_t                    ext [EXT_CNT];
  logic [POS_CNT-1:0]         pass;
  logic [RUN_CNT-1:0]         run;
  logic [RUN_CNT-1:0]         in_win;
  logic signed [SAMPLE_W:0]   thr_ext;
  logic signed [WIN_W-1:0]    wf_ext;
  logic signed [WIN_W-1:0]    wl_ext;
  logic signed [WIN_W-1:0]    lo;
  logic signed [WIN_W-1:0]    hi;
  logic [WIN_W-1:0]           reach;

  assign thr_ext = $signed({1'b0, cfg.threshold});
  assign wf_ext  = WIN_W'(cfg.window_first);
  assign wl_ext  = $signed({{(WIN_W - WLAST_W){1'b0}}, cfg.window_last});

  // samples by crossing position, zero outside the stored history
  for (genvar i = 0; i < EXT_CNT; i++) begin : g_ext
    localparam int Age = SPC - 1 - (POS_MIN + i);
    if (Age >= 0 && Age < DEPTH) begin : g_stored
      assign ext[i] = hist[Age];
    end else begin : g_zero
      assign ext[i] = '0;
    end
  end

  // pair test at every position
  for (genvar i = 0; i < POS_CNT; i++) begin : g_pass
    logic [EXT_IDX_W-1:0]     far_idx;
    logic signed [SAMPLE_W:0] diff;
    assign far_idx = EXT_IDX_W'(i) + EXT_IDX_W'(cfg.pair_shift);
    assign diff    = (SAMPLE_W + 1)'(ext[i]) - (SAMPLE_W + 1)'(ext[far_idx]);
    assign pass[i] = diff > thr_ext;
  end

  // allowed start positions of a run
  assign lo = cfg.double_mode ? wf_ext : wf_ext - WIN_W'(1);
  assign hi = cfg.double_mode ? wl_ext : wl_ext - WIN_W'(1);

  // consecutive passes starting at each position, gated by the window
  for (genvar j = 0; j < RUN_CNT; j++) begin : g_run
    localparam logic signed [WIN_W-1:0] QPos = WIN_W'(POS_MIN + j);
    assign run[j]    = cfg.double_mode ? (pass[j] & pass[j+1])
                                       : (pass[j] & pass[j+1] & pass[j+2]);
    assign in_win[j] = (QPos >= lo) && (QPos <= hi);
  end

  // window end plus pair distance running past the crossing
  assign reach = WIN_W'(cfg.window_last) + WIN_W'(cfg.pair_shift) + WIN_W'(1);

  assign verdict.triggered      = |(run & in_win);
  assign verdict.settings_error = reach >= WIN_W'(SPC);

endmodule

/* rtl/core/sample_difference_trigger.sv */
`timescale 1ns / 1ps

// Single-channel sample difference trigger.
// Input channel: one signed 12-bit ADC sample per transfer (in_sample), with
// in_bc_end high on the last sample of a bunch crossing. A transfer takes
// place when in_valid is high and in_stall is low.
// Result channel: one transfer per crossing end, carrying out_triggered (the
// consecutive-pass condition held inside the search window) and
// out_settings_error (window end plus pair distance runs past the crossing).
// Configuration: cfg_index selects threshold, pair_shift, window_first,
// window_last or double_mode; cfg_data is written when cfg_valid is high
// (cfg_ready is always high). Write only while no result is outstanding.
// The last sample of a crossing is registered in the sample shift line, and the
// result register takes its verdict once free. Throughput: one sample per cycle
// while in_stall is low; the pair tests and window search sit in one stage
// between the sample shift line and the result register.
// Reset clears the sample history to zero, drops any pending result and
// restores the register defaults (pair_shift 1, all others 0).
// When the receiver stalls, the result register holds; further samples are
// still taken until a second crossing end is waiting, then in_stall rises.

module sample_difference_trigger
  import sdt_pkg::*;
#(
  parameter int SAMPLES_PER_CROSSING = 12,
  parameter int HISTORY_DEPTH        = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [11:0]    in_sample,
  input  logic                  in_bc_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_triggered,
  output logic                  out_settings_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  sample_t  hist [HISTORY_DEPTH];
  logic     pend;
  logic     out_free;
  logic     taken;
  logic     in_accept;
  verdict_t verdict;

  logic     out_valid_r;
  logic     out_valid_nxt;
  verdict_t out_data_r;

  assign cfg_ready = 1'b1;

  sdt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign taken     = pend && out_free;
  assign in_stall  = pend && !out_free;
  assign in_accept = in_valid && !in_stall;

  sdt_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .sample (in_sample),
    .bc_end (in_bc_end),
    .taken  (taken),
    .hist   (hist),
    .pend   (pend)
  );

  sdt_eval #(
    .SPC   (SAMPLES_PER_CROSSING),
    .DEPTH (HISTORY_DEPTH)
  ) u_eval (
    .hist    (hist),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (taken) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_triggered      = out_data_r.triggered;
  assign out_settings_error = out_data_r.settings_error;

endmodule

/* dv/tb_sample_difference_trigger.sv */
`timescale 1ns / 1ps

module tb_sample_difference_trigger;
  import sdt_pkg::*;

  localparam int SAMPLES_PER_CROSSING = 12;
  localparam int HISTORY_DEPTH        = 24;
  localparam int PHASES               = 10;
  localparam int ITEMS_PER_PHASE      = 195;
  localparam int REG_COUNT            = int'(REG_DOUBLE_MODE) + 1;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(REG_COUNT);
  localparam logic [CFG_IDX_W-1:0] LAST_IDX        = '1;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               sample;
    logic                  bc_end;
    logic                  typed;
    verdict_t              want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               in_sample = '0;
  logic                  in_bc_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_triggered;
  logic                  out_settings_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  sample_t  sample_line [HISTORY_DEPTH];
  cfg_t     model_cfg;
  verdict_t verdict_queue [$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  sample_difference_trigger dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_bc_end          (in_bc_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_triggered      (out_triggered),
    .out_settings_error (out_settings_error),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // sample at crossing position p, zero outside the stored history
  function automatic int sample_at(int p);
    int age;
    age = SAMPLES_PER_CROSSING - 1 - p;
    if (age < 0 || age >= HISTORY_DEPTH) return 0;
    return int'(sample_line[age]);
  endfunction

  // consecutive-pass search over the window, plus the settings check
  function automatic verdict_t trigger_verdict();
    int       start;
    int       stop;
    int       diff;
    bit       ok;
    bit       prev;
    bit       pprev;
    verdict_t v;
    v = '0;
    prev = 1'b0;
    pprev = 1'b0;
    start = model_cfg.double_mode ? int'(model_cfg.window_first)
                                  : int'(model_cfg.window_first) - 1;
    stop = int'(model_cfg.window_last) + 2;
    for (int p = start; p < stop; p++) begin
      diff = sample_at(p) - sample_at(p + int'(model_cfg.pair_shift));
      ok = diff > int'(model_cfg.threshold);
      if (ok && prev && (model_cfg.double_mode || pprev)) begin
        v.triggered = 1'b1;
        break;
      end
      pprev = prev;
      prev = ok;
    end
    v.settings_error = int'(model_cfg.window_last) + int'(model_cfg.pair_shift) + 1
                       >= SAMPLES_PER_CROSSING;
    return v;
  endfunction

  function automatic row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t item_row(sample_t s, logic e);
    row_t r;
    r = '{ROW_ITEM, '0, '0, s, e, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t known_row(sample_t s, logic e, logic trig, logic err);
    row_t r;
    r = '{ROW_ITEM, '0, '0, s, e, 1'b1, '0};
    r.want.triggered = trig;
    r.want.settings_error = err;
    return r;
  endfunction

  // one sample transfer, with random idle cycles ahead of it
  task automatic send_item(input sample_t s, input logic e, input logic typed,
                           input verdict_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_bc_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
    sample_line[0] = s;
    if (e) verdict_queue.push_back(typed ? want : trigger_verdict());
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THRESHOLD:    model_cfg.threshold    = data[THR_W-1:0];
      REG_PAIR_SHIFT:   model_cfg.pair_shift   = data[SHIFT_W-1:0];
      REG_WINDOW_FIRST: model_cfg.window_first = data[WFIRST_W-1:0];
      REG_WINDOW_LAST:  model_cfg.window_last  = data[WLAST_W-1:0];
      REG_DOUBLE_MODE:  model_cfg.double_mode  = data[0];
      default: ;
    endcase
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: result with nothing expected: triggered=%b settings_error=%b",
                 $time, out_triggered, out_settings_error);
        mismatch_count++;
      end else begin
        want = verdict_queue[0];
        verdict_queue.delete(0);
        if (out_triggered !== want.triggered) begin
          $display("%0t: triggered mismatch: expected %b, actual %b",
                   $time, want.triggered, out_triggered);
          mismatch_count++;
        end
        if (out_settings_error !== want.settings_error) begin
          $display("%0t: settings_error mismatch: expected %b, actual %b",
                   $time, want.settings_error, out_settings_error);
          mismatch_count++;
        end
      end
    end
  end

  // timeout
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    row_t                  plan [$];
    logic [CFG_DATA_W-1:0] regval [REG_COUNT];
    int                    sent;
    int                    len;
    int                    step_at;
    int                    hi;
    int                    lo;
    int                    v;
    bit                    pulse;

    foreach (sample_line[i]) sample_line[i] = '0;
    model_cfg = '0;
    model_cfg.pair_shift = 1;

    // directed part
    plan = '{
      // fresh history after reset gives nothing
      known_row(0, 1'b1, 1'b0, 1'b0),
      // threshold at its maximum can never be exceeded; window runs past the crossing
      cfg_row(REG_THRESHOLD, 12'hFFF),
      cfg_row(REG_PAIR_SHIFT, 12'd11),
      cfg_row(REG_WINDOW_LAST, 12'd11),
      known_row(2047, 1'b1, 1'b0, 1'b1),
      // full-scale step seen by two pairs in double mode
      cfg_row(REG_THRESHOLD, 12'd4094),
      cfg_row(REG_PAIR_SHIFT, 12'd2),
      cfg_row(REG_WINDOW_LAST, 12'd0),
      cfg_row(REG_DOUBLE_MODE, 12'd1),
      item_row(2047, 1'b0), item_row(2047, 1'b0),
      item_row(-2048, 1'b0), item_row(-2048, 1'b0),
      item_row(0, 1'b0), item_row(0, 1'b0), item_row(0, 1'b0), item_row(0, 1'b0),
      item_row(0, 1'b0), item_row(0, 1'b0), item_row(0, 1'b0),
      known_row(0, 1'b1, 1'b1, 1'b0),
      // zero pair distance compares a sample with itself; window past the history
      cfg_row(REG_PAIR_SHIFT, 12'd0),
      cfg_row(REG_THRESHOLD, 12'd0),
      cfg_row(REG_DOUBLE_MODE, 12'd0),
      cfg_row(REG_WINDOW_FIRST, 12'h010),
      cfg_row(REG_WINDOW_LAST, 12'd15),
      known_row(-2048, 1'b1, 1'b0, 1'b1),
      // positions after the crossing end read as zero
      cfg_row(REG_PAIR_SHIFT, 12'd15),
      cfg_row(REG_WINDOW_FIRST, 12'h00F),
      item_row(-2048, 1'b0), item_row(2047, 1'b1),
      // window reaching back into the previous crossing
      cfg_row(REG_PAIR_SHIFT, 12'd1),
      cfg_row(REG_WINDOW_FIRST, 12'h015),
      cfg_row(REG_WINDOW_LAST, 12'd11),
      item_row(1000, 1'b0), item_row(-1000, 1'b0), item_row(5, 1'b1)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind == ROW_ITEM) drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (i > 0 && plan[i-1].kind == ROW_CFG) cfg_valid <= 1'b0;
        send_item(plan[i].sample, plan[i].bc_end, plan[i].typed, plan[i].want);
      end
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          regval[REG_THRESHOLD]    = 12'd0;
          regval[REG_PAIR_SHIFT]   = 12'd1;
          regval[REG_WINDOW_FIRST] = 12'd0;
          regval[REG_WINDOW_LAST]  = 12'd0;
          regval[REG_DOUBLE_MODE]  = 12'd0;
        end
        1: begin
          regval[REG_THRESHOLD]    = 12'd0;
          regval[REG_PAIR_SHIFT]   = 12'd1;
          regval[REG_WINDOW_FIRST] = 12'h010;
          regval[REG_WINDOW_LAST]  = 12'd15;
          regval[REG_DOUBLE_MODE]  = 12'd0;
        end
        2: begin
          regval[REG_THRESHOLD]    = 12'hFFF;
          regval[REG_PAIR_SHIFT]   = 12'd15;
          regval[REG_WINDOW_FIRST] = 12'h00F;
          regval[REG_WINDOW_LAST]  = 12'd0;
          regval[REG_DOUBLE_MODE]  = 12'd1;
        end
        default: begin
          regval[REG_THRESHOLD] = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                              ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 800));
          regval[REG_PAIR_SHIFT]   = CFG_DATA_W'($urandom_range(0, 4095));
          regval[REG_WINDOW_FIRST] = CFG_DATA_W'($urandom_range(0, 4095));
          regval[REG_WINDOW_LAST]  = CFG_DATA_W'($urandom_range(0, 4095));
          regval[REG_DOUBLE_MODE]  = CFG_DATA_W'($urandom_range(0, 4095));
        end
      endcase
      for (int r = 0; r < REG_COUNT; r++) write_reg(r[CFG_IDX_W-1:0], regval[r]);
      // unused indexes are ignored
      if (ph >= 3) begin
        write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, LAST_IDX)),
                  CFG_DATA_W'($urandom_range(0, 4095)));
      end
      cfg_valid <= 1'b0;

      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // mostly full crossings, some cut short or running long
        len = ($urandom_range(0, 9) < 8) ? SAMPLES_PER_CROSSING : $urandom_range(1, 24);
        pulse = $urandom_range(0, 9) < 6;
        step_at = $urandom_range(0, len - 1);
        hi = int'($urandom_range(0, 4095)) - 2048;
        lo = hi - int'($urandom_range(0, hi + 2048));
        for (int k = 0; k < len; k++) begin
          if (pulse) v = (k < step_at) ? hi : lo;
          else v = int'($urandom_range(0, 4095)) - 2048;
          send_item(sample_t'(v), k == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
